### hdl/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg
// Shared types and constants of the axis to MIDI controller: table entry
// layout, mode codes, MIDI status nibbles and configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package amc_pkg;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 24;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned WORD_W     = 57;
  localparam int unsigned ENTRY_W    = 19;
  localparam int unsigned CHANNEL_W  = 4;

  // axes covered by the tables, three entries to a word
  localparam logic [2:0] TABLE_AXES      = 3'd6;
  localparam logic [2:0] AXES_PER_WORD   = 3'd3;

  // value widths
  localparam int unsigned CC_W   = 7;
  localparam int unsigned BEND_W = 14;

  // values for a bipolar sample snapped to the center
  localparam logic [CC_W-1:0]   CC_CENTER   = 7'd63;
  localparam logic [BEND_W-1:0] BEND_CENTER = 14'd8191;

  // status byte high nibbles
  localparam logic [3:0] STATUS_CC   = 4'hB;
  localparam logic [3:0] STATUS_BEND = 4'hE;

  // entry mode codes
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_CC    = 2'd1,
    MODE_BEND  = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  // one table entry, lowest field in the lowest bits
  typedef struct packed {
    logic [7:0]      deadzone;
    logic            invert;
    logic            bipolar;
    logic [CC_W-1:0] ccnum;
    mode_t           mode;
  } axis_entry_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CHANNEL     = 3'd0,
    REG_NORMAL_LOW  = 3'd1,
    REG_NORMAL_HIGH = 3'd2,
    REG_SHIFT_LOW   = 3'd3,
    REG_SHIFT_HIGH  = 3'd4
  } reg_index_t;

endpackage

`default_nettype wire

### hdl/axis_to_midi_controller_top.sv
// ----------------------------------------------------------------------------
// axis_to_midi_controller_top
// Maps joystick axis samples to MIDI control change or pitch bend messages,
// sending a message only when the value for that axis has changed or none has been sent yet.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tdata: axis_sample; tuser: axis_number, shift_held
//  m_axis    | out       | tdata: status_byte, first_data, second_data
//  apb       | in/out    | 64-bit registers at 8*i, write and read back
//
//  one item per cycle while m_axis is not stalled; items pass stage 1, stage 2, output register
//  reset clears the configuration registers, valid flags and per-axis send history at once
//  a stalled m_axis holds stage 2; stage 1 still fills behind it, then
//  s_axis_tready drops until the output moves again
//  latency and rate are set by the two compute stages and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module axis_to_midi_controller_top #(
  parameter int unsigned AXIS_COUNT = 6
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // slave stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [amc_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [15:0] axis_sample
  input  wire logic [amc_pkg::IN_USER_W-1:0]   s_axis_tuser,  // [2:0] axis_number, [3] shift_held
  // master stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [amc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // [7:0] status_byte,
                                                              // [14:8] first_data,
                                                              // [21:15] second_data
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [amc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [amc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [amc_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  import amc_pkg::*;

  localparam int unsigned AXIS_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  // configuration registers
  logic [CHANNEL_W-1:0] midi_channel;
  logic [WORD_W-1:0]    normal_low;
  logic [WORD_W-1:0]    normal_high;
  logic [WORD_W-1:0]    shift_low;
  logic [WORD_W-1:0]    shift_high;
  reg_index_t           cfg_index;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_index = reg_index_t'(paddr[5:3]);
  assign cfg_write = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel <= '0;
      normal_low   <= '0;
      normal_high  <= '0;
      shift_low    <= '0;
      shift_high   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNEL:     midi_channel <= pwdata[CHANNEL_W-1:0];
        REG_NORMAL_LOW:  normal_low   <= pwdata[WORD_W-1:0];
        REG_NORMAL_HIGH: normal_high  <= pwdata[WORD_W-1:0];
        REG_SHIFT_LOW:   shift_low    <= pwdata[WORD_W-1:0];
        REG_SHIFT_HIGH:  shift_high   <= pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_index)
      REG_CHANNEL:     prdata = {{(CFG_DATA_W-CHANNEL_W){1'b0}}, midi_channel};
      REG_NORMAL_LOW:  prdata = {{(CFG_DATA_W-WORD_W){1'b0}}, normal_low};
      REG_NORMAL_HIGH: prdata = {{(CFG_DATA_W-WORD_W){1'b0}}, normal_high};
      REG_SHIFT_LOW:   prdata = {{(CFG_DATA_W-WORD_W){1'b0}}, shift_low};
      REG_SHIFT_HIGH:  prdata = {{(CFG_DATA_W-WORD_W){1'b0}}, shift_high};
      default:         prdata = '0;
    endcase
  end

  // pipeline handshake: stage 2 moves into the output register when it is free
  logic s1_valid, s2_valid, out_valid;
  logic out_free, s2_fire, s2_take, s1_take;

  assign out_free      = !out_valid || m_axis_tready;
  assign s2_fire       = s2_valid && out_free;
  assign s2_take       = !s2_valid || s2_fire;
  assign s1_take       = !s1_valid || s2_take;
  assign s_axis_tready = s1_take;

  // stage 1: input register
  logic [2:0]           s1_axis;
  logic [IN_DATA_W-1:0] s1_sample;
  logic                 s1_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s1_take) begin
      s1_sample <= s_axis_tdata;
      s1_axis   <= s_axis_tuser[2:0];
      s1_shift  <= s_axis_tuser[3];
    end
  end

  // table entry lookup
  logic [WORD_W-1:0] s1_word;
  logic [1:0]        s1_slot;
  axis_entry_t       s1_entry;
  logic              s1_active;

  always_comb begin
    if (s1_axis < AXES_PER_WORD) begin
      s1_word = s1_shift ? shift_low : normal_low;
      s1_slot = s1_axis[1:0];
    end else begin
      s1_word = s1_shift ? shift_high : normal_high;
      s1_slot = 2'(s1_axis - AXES_PER_WORD);
    end
    if (s1_axis >= TABLE_AXES) begin
      s1_entry = '0;
    end else begin
      unique case (s1_slot)
        2'd0:    s1_entry = axis_entry_t'(s1_word[ENTRY_W-1:0]);
        2'd1:    s1_entry = axis_entry_t'(s1_word[2*ENTRY_W-1:ENTRY_W]);
        2'd2:    s1_entry = axis_entry_t'(s1_word[3*ENTRY_W-1:2*ENTRY_W]);
        default: s1_entry = '0;
      endcase
    end
  end

  assign s1_active = ({1'b0, s1_axis} < 4'(AXIS_COUNT)) &&
                     ((s1_entry.mode == MODE_CC) || (s1_entry.mode == MODE_BEND));

  // normalization with deadzone and inversion
  logic [15:0] bi_u;
  logic [15:0] bi_dist;
  logic [23:0] bi_limit;
  logic        bi_snap;
  logic [14:0] uni_p;
  logic [22:0] uni_limit;
  logic [14:0] uni_kept;
  logic [15:0] s1_val;

  assign bi_u      = s1_sample ^ 16'h8000;
  // |2u - 65535| is odd, so it is the folded half with a one below it
  assign bi_dist   = {bi_u[15] ? bi_u[14:0] : ~bi_u[14:0], 1'b1};
  assign bi_limit  = {s1_entry.deadzone, 16'b0} - {16'b0, s1_entry.deadzone};
  assign bi_snap   = {bi_dist, 8'b0} < bi_limit;
  assign uni_p     = s1_sample[15] ? 15'd0 : s1_sample[14:0];
  assign uni_limit = {s1_entry.deadzone, 15'b0} - {15'b0, s1_entry.deadzone};
  assign uni_kept  = ({uni_p, 8'b0} < uni_limit) ? 15'd0 : uni_p;

  always_comb begin
    if (s1_entry.bipolar) begin
      s1_val = s1_entry.invert ? ~bi_u : bi_u;
    end else begin
      s1_val = {1'b0, s1_entry.invert ? ~uni_kept : uni_kept};
    end
  end

  // stage 2 registers
  logic              s2_bipolar;
  logic              s2_snap;
  logic              s2_bend;
  logic [CC_W-1:0]   s2_ccnum;
  logic [AXIS_W-1:0] s2_axis;
  logic [15:0]       s2_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_take) begin
      s2_valid <= s1_valid && s1_active;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_bipolar <= s1_entry.bipolar;
      s2_snap    <= s1_entry.bipolar && bi_snap;
      s2_bend    <= (s1_entry.mode == MODE_BEND);
      s2_ccnum   <= s1_entry.ccnum;
      s2_axis    <= s1_axis[AXIS_W-1:0];
      s2_val     <= s1_val;
    end
  end

  // scaling: x/65535 = (x>>16) + ((x>>16) + low 16 bits >= 65535), same for 32767
  logic [22:0]       bi_cc_prod;
  logic [16:0]       bi_cc_sum;
  logic [29:0]       bi_bend_prod;
  logic [16:0]       bi_bend_sum;
  logic [21:0]       uni_cc_prod;
  logic [15:0]       uni_cc_sum;
  logic [28:0]       uni_bend_prod;
  logic [15:0]       uni_bend_sum;
  logic [CC_W-1:0]   cc_value;
  logic [BEND_W-1:0] bend_value;

  assign bi_cc_prod    = {s2_val, 7'b0} - {7'b0, s2_val};
  assign bi_cc_sum     = {10'b0, bi_cc_prod[22:16]} + {1'b0, bi_cc_prod[15:0]};
  assign bi_bend_prod  = {s2_val, 14'b0} - {14'b0, s2_val};
  assign bi_bend_sum   = {3'b0, bi_bend_prod[29:16]} + {1'b0, bi_bend_prod[15:0]};
  assign uni_cc_prod   = {s2_val[14:0], 7'b0} - {7'b0, s2_val[14:0]};
  assign uni_cc_sum    = {9'b0, uni_cc_prod[21:15]} + {1'b0, uni_cc_prod[14:0]};
  assign uni_bend_prod = {s2_val[14:0], 14'b0} - {14'b0, s2_val[14:0]};
  assign uni_bend_sum  = {2'b0, uni_bend_prod[28:15]} + {1'b0, uni_bend_prod[14:0]};

  always_comb begin
    if (s2_snap) begin
      cc_value   = CC_CENTER;
      bend_value = BEND_CENTER;
    end else if (s2_bipolar) begin
      cc_value   = bi_cc_prod[22:16] + CC_W'(bi_cc_sum >= 17'd65535);
      bend_value = bi_bend_prod[29:16] + BEND_W'(bi_bend_sum >= 17'd65535);
    end else begin
      cc_value   = uni_cc_prod[21:15] + CC_W'(uni_cc_sum >= 16'd32767);
      bend_value = uni_bend_prod[28:15] + BEND_W'(uni_bend_sum >= 16'd32767);
    end
  end

  // per-axis send history, one set for each message kind
  logic [AXIS_COUNT-1:0] cc_seen;
  logic [AXIS_COUNT-1:0] bend_seen;
  logic [CC_W-1:0]       cc_last   [AXIS_COUNT];
  logic [BEND_W-1:0]     bend_last [AXIS_COUNT];
  logic                  s2_emit;

  always_comb begin
    if (s2_bend) begin
      s2_emit = !(bend_seen[s2_axis] && (bend_last[s2_axis] == bend_value));
    end else begin
      s2_emit = !(cc_seen[s2_axis] && (cc_last[s2_axis] == cc_value));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc_seen   <= '0;
      bend_seen <= '0;
    end else if (s2_fire && s2_emit) begin
      if (s2_bend) begin
        bend_seen[s2_axis] <= 1'b1;
      end else begin
        cc_seen[s2_axis] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_emit) begin
      if (s2_bend) begin
        bend_last[s2_axis] <= bend_value;
      end else begin
        cc_last[s2_axis] <= cc_value;
      end
    end
  end

  // output register
  logic [7:0]      out_status;
  logic [CC_W-1:0] out_first;
  logic [CC_W-1:0] out_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      if (s2_bend) begin
        out_status <= {STATUS_BEND, midi_channel};
        out_first  <= bend_value[CC_W-1:0];
        out_second <= bend_value[BEND_W-1:CC_W];
      end else begin
        out_status <= {STATUS_CC, midi_channel};
        out_first  <= s2_ccnum;
        out_second <= cc_value;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b0, out_second, out_first, out_status};

  // a fired item shows up as a message exactly when it was a change or a first send
  a_emit_to_out: assert property (@(posedge clk) disable iff (rst)
    s2_fire |=> (out_valid == $past(s2_emit)))
    else $error("output valid does not follow the change decision");

  // a sent message leaves its value in the history of its kind
  a_history_set: assert property (@(posedge clk) disable iff (rst)
    s2_fire && s2_emit && !s2_bend |=> cc_seen[$past(s2_axis)] &&
      (cc_last[$past(s2_axis)] == $past(cc_value)))
    else $error("control change history not updated");

  a_bend_history_set: assert property (@(posedge clk) disable iff (rst)
    s2_fire && s2_emit && s2_bend |=> bend_seen[$past(s2_axis)] &&
      (bend_last[$past(s2_axis)] == $past(bend_value)))
    else $error("pitch bend history not updated");

  // every message carries one of the two status kinds
  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m_axis_tdata[7:4] == STATUS_CC) || (m_axis_tdata[7:4] == STATUS_BEND))
    else $error("bad status byte on output");

  // a held stage 2 item is not dropped while the output stalls
  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_free |=> s2_valid && $stable(s2_val))
    else $error("stage 2 item lost during stall");

endmodule

`default_nettype wire
